FILE: sv/fdc_pkg.sv
// Shared types, constants and the CRC byte update for the frame deframer.
`timescale 1ns / 1ps

package fdc_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned CMP_W       = 18;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_W-1:0]       POS_MAX    = '1;
  localparam logic [15:0]            CRC_INIT   = 16'hFFFF;
  localparam logic [15:0]            CRC_POLY   = 16'h1021;
  localparam logic [CMP_W-1:0]       MIN_FRAME  = CMP_W'(11);
  localparam logic [7:0]             START_RESET = 8'd2;
  localparam logic [7:0]             END_RESET   = 8'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER   = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    KIND_TYPE         = 3'd0,
    KIND_ID           = 3'd1,
    KIND_QOS          = 3'd2,
    KIND_TOPIC_LEN    = 3'd3,
    KIND_TOPIC_BYTE   = 3'd4,
    KIND_PAYLOAD_LEN  = 3'd5,
    KIND_PAYLOAD_BYTE = 3'd6,
    KIND_STATUS       = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_TOO_SHORT       = 3'd1,
    ST_BAD_START       = 3'd2,
    ST_TOPIC_OVERRUN   = 3'd3,
    ST_PAYLOAD_OVERRUN = 3'd4,
    ST_CRC_MISMATCH    = 3'd5,
    ST_BAD_END         = 3'd6
  } status_t;

  // One queue entry: the results that one received byte produces.
  typedef struct packed {
    logic        field_valid;
    kind_t       field_kind;
    logic [15:0] field_value;
    logic        status_valid;
    status_t     status_code;
  } fdc_entry_t;

  // CRC16-CCITT update by one byte, MSB first, no reflection.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/frame_deframer_crc16_unit.sv
// Top level of the framed-message deframer with CRC16-CCITT check.
`timescale 1ns / 1ps

// The deframer takes a received buffer one byte per transaction on the byte
// channel, with last_byte set on the buffer's final byte. It reports the
// header fields (type, 16-bit id, qos, topic length, payload length) and every
// topic and payload byte as soon as each is complete, purely by position, and
// on the final byte it adds a status result: ok, too short, bad start, topic
// overrun, payload overrun, CRC mismatch or bad end, the first failing check
// in that order. The CRC is CCITT (init FFFF, poly 1021) over the type through
// the last payload byte. After the final byte all parse state clears for the
// next buffer. A byte is accepted every clock cycle while the four-entry queue
// between the parser and the result stage has room; the result stage sends one
// result per cycle while the output side is not stalled, so a final byte that
// also completes a field yields two results, the field and then the status.
// Each result passes through the queue and the registered output stage and is
// taken when the output side is not stalled. The start and end markers are
// written on the configuration channel (index 0 and 1, reset values 2 and 3),
// which is always ready; writes to other indexes are ignored, and the markers
// should be changed only while no buffer is in progress.
module frame_deframer_crc16_unit import fdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [2:0]             kind,
  output logic [15:0]            value,
  output logic                   final_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  logic [7:0] start_marker;
  logic [7:0] end_marker;

  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       head_valid;
  fdc_entry_t push_entry;
  fdc_entry_t head_entry;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_RESET;
      end_marker   <= END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_START_MARKER) begin
        start_marker <= cfg_data;
      end else if (cfg_index == CFG_END_MARKER) begin
        end_marker <= cfg_data;
      end
    end
  end

  // The parser stalls only when the queue is full.
  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  fdc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .push         (push),
    .entry        (push_entry)
  );

  fdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  fdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .value      (value),
    .final_res  (final_res)
  );

endmodule

FILE: sv/fdc_front.sv
// Byte parser: tracks frame position, CRC and checks, and builds queue entries.
`timescale 1ns / 1ps

module fdc_front import fdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  output logic       push,
  output fdc_entry_t entry
);

  logic [POS_W-1:0] byte_position;
  logic [15:0]      running_crc;
  logic [7:0]       held_high_byte;
  logic [7:0]       topic_count;
  logic [15:0]      payload_count;
  logic             start_seen_ok;
  logic             crc_ok;
  logic             end_seen_ok;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_crc_next;
  logic [7:0]       held_high_byte_next;
  logic [7:0]       topic_count_next;
  logic [15:0]      payload_count_next;
  logic             start_seen_ok_next;
  logic             crc_ok_next;
  logic             end_seen_ok_next;

  logic [CMP_W-1:0] p;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] topic_end;
  logic [CMP_W-1:0] crc_hi;
  logic [CMP_W-1:0] need_topic;
  logic [CMP_W-1:0] need_payload;
  logic             fld_valid;
  kind_t            fld_kind;
  logic [15:0]      fld_value;
  status_t          code;

  assign p         = CMP_W'(byte_position);
  assign len       = p + CMP_W'(1);
  assign topic_end = CMP_W'(6) + CMP_W'(topic_count);
  assign crc_hi    = CMP_W'(8) + CMP_W'(topic_count) + CMP_W'(payload_count);

  // Field decode by position; bounds use the lengths known before this byte.
  always_comb begin
    held_high_byte_next = held_high_byte;
    topic_count_next    = topic_count;
    payload_count_next  = payload_count;
    start_seen_ok_next  = start_seen_ok;
    crc_ok_next         = crc_ok;
    end_seen_ok_next    = end_seen_ok;
    fld_valid           = 1'b0;
    fld_kind            = KIND_TYPE;
    fld_value           = {8'h00, data_byte};

    if ((p >= CMP_W'(1)) && (p < crc_hi)) begin
      running_crc_next = crc_feed(running_crc, data_byte);
    end else begin
      running_crc_next = running_crc;
    end

    if (p == CMP_W'(0)) begin
      start_seen_ok_next = (data_byte == start_marker);
    end else if (p == CMP_W'(1)) begin
      fld_valid = 1'b1;
      fld_kind  = KIND_TYPE;
    end else if (p == CMP_W'(2)) begin
      held_high_byte_next = data_byte;
    end else if (p == CMP_W'(3)) begin
      fld_valid = 1'b1;
      fld_kind  = KIND_ID;
      fld_value = {held_high_byte, data_byte};
    end else if (p == CMP_W'(4)) begin
      fld_valid = 1'b1;
      fld_kind  = KIND_QOS;
    end else if (p == CMP_W'(5)) begin
      fld_valid        = 1'b1;
      fld_kind         = KIND_TOPIC_LEN;
      topic_count_next = data_byte;
    end else if (p < topic_end) begin
      fld_valid = 1'b1;
      fld_kind  = KIND_TOPIC_BYTE;
    end else if (p == topic_end) begin
      held_high_byte_next = data_byte;
    end else if (p == topic_end + CMP_W'(1)) begin
      fld_valid          = 1'b1;
      fld_kind           = KIND_PAYLOAD_LEN;
      fld_value          = {held_high_byte, data_byte};
      payload_count_next = {held_high_byte, data_byte};
    end else if (p < crc_hi) begin
      fld_valid = 1'b1;
      fld_kind  = KIND_PAYLOAD_BYTE;
    end else if (p == crc_hi) begin
      held_high_byte_next = data_byte;
    end else if (p == crc_hi + CMP_W'(1)) begin
      crc_ok_next = ({held_high_byte, data_byte} == running_crc);
    end else if (p == crc_hi + CMP_W'(2)) begin
      end_seen_ok_next = (data_byte == end_marker);
    end
  end

  // Status checks use the state as it stands after this byte.
  assign need_topic   = CMP_W'(8) + CMP_W'(topic_count_next);
  assign need_payload = CMP_W'(11) + CMP_W'(topic_count_next) + CMP_W'(payload_count_next);

  always_comb begin
    if (len < MIN_FRAME) begin
      code = ST_TOO_SHORT;
    end else if (!start_seen_ok_next) begin
      code = ST_BAD_START;
    end else if (need_topic > len) begin
      code = ST_TOPIC_OVERRUN;
    end else if (need_payload > len) begin
      code = ST_PAYLOAD_OVERRUN;
    end else if (!crc_ok_next) begin
      code = ST_CRC_MISMATCH;
    end else if (!end_seen_ok_next) begin
      code = ST_BAD_END;
    end else begin
      code = ST_OK;
    end
  end

  always_comb begin
    if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
    end else begin
      byte_position_next = byte_position;
    end
  end

  assign push               = accept && (fld_valid || last_byte);
  assign entry.field_valid  = fld_valid;
  assign entry.field_kind   = fld_kind;
  assign entry.field_value  = fld_value;
  assign entry.status_valid = last_byte;
  assign entry.status_code  = code;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_position  <= '0;
      running_crc    <= CRC_INIT;
      held_high_byte <= '0;
      topic_count    <= '0;
      payload_count  <= '0;
      start_seen_ok  <= 1'b0;
      crc_ok         <= 1'b0;
      end_seen_ok    <= 1'b0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      running_crc    <= running_crc_next;
      held_high_byte <= held_high_byte_next;
      topic_count    <= topic_count_next;
      payload_count  <= payload_count_next;
      start_seen_ok  <= start_seen_ok_next;
      crc_ok         <= crc_ok_next;
      end_seen_ok    <= end_seen_ok_next;
    end
  end

endmodule

FILE: sv/fdc_queue.sv
// Small FIFO of parsed entries between the parser and the result stage.
`timescale 1ns / 1ps

module fdc_queue import fdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fdc_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output fdc_entry_t head_entry
);

  fdc_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/fdc_back.sv
// Result stage: expands each queue entry into one or two output results.
`timescale 1ns / 1ps

module fdc_back import fdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  fdc_entry_t  head_entry,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [15:0] value,
  output logic        final_res
);

  logic  load;
  logic  both;
  logic  second;
  logic  emit_status;
  kind_t kind_sel;

  assign load        = head_valid && (!res_valid || !res_stall);
  assign both        = head_entry.field_valid && head_entry.status_valid;
  assign pop         = load && !(both && !second);
  assign emit_status = second || !head_entry.field_valid;
  assign kind_sel    = emit_status ? KIND_STATUS : head_entry.field_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        second    <= both && !second;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind      <= kind_sel;
      value     <= emit_status ? 16'(head_entry.status_code) : head_entry.field_value;
      final_res <= pop;
    end
  end

endmodule
